// ===== rtl/rpsg_pkg.sv =====
package rpsg_pkg;

   // fixed point of the cooldown accumulator
   localparam int FRAC_BITS = 8;

   localparam int TEMP_W = 9;
   localparam int RISE_W = 6;
   localparam int SEC_W  = 10;
   localparam int PT_W   = 12;
   localparam int LEN_W  = PT_W + 1;
   localparam int IDX_W  = 4;
   localparam int DATA_W = 10;

   // divider operands: temperature difference scaled by the fraction bits
   localparam int DIV_W     = TEMP_W + FRAC_BITS;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);
   localparam int STEP_W    = DIV_W + 1;
   // start value plus up to 1023 steps of the widest step, signed
   localparam int ACC_W     = TEMP_W + FRAC_BITS + SEC_W + 1;

   localparam logic [TEMP_W-1:0] AMBIENT_TEMP = TEMP_W'(25);

   localparam logic [IDX_W-1:0] CSR_SOAK_LEVEL  = IDX_W'(0);
   localparam logic [IDX_W-1:0] CSR_PREHEAT     = IDX_W'(1);
   localparam logic [IDX_W-1:0] CSR_SOAK_SEC    = IDX_W'(2);
   localparam logic [IDX_W-1:0] CSR_PEAK_LEVEL  = IDX_W'(3);
   localparam logic [IDX_W-1:0] CSR_PEAK_RISE   = IDX_W'(4);
   localparam logic [IDX_W-1:0] CSR_REFLOW_SEC  = IDX_W'(5);
   localparam logic [IDX_W-1:0] CSR_COOL_SEC    = IDX_W'(6);
   localparam logic [IDX_W-1:0] CSR_COOL_FLOOR  = IDX_W'(7);

   typedef enum logic [2:0] {
      PH_AMBIENT,
      PH_PREHEAT,
      PH_SOAK,
      PH_RAMP,
      PH_REFLOW,
      PH_COOL,
      PH_HOLD
   } phase_type;

   typedef enum logic [1:0] {
      SEL_PRE,
      SEL_RAMP,
      SEL_STEP
   } div_sel_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic        tick;
      logic        restart;
      logic        div_start;
      logic        div_store;
      div_sel_type div_sel;
      logic        load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic div_done;
   } dp_status_type;

endpackage

// ===== rtl/reflow_profile_setpoint_generator_core.sv =====
// reflow oven setpoint profile generator
// req channel: one transfer per one-second tick; req_restart high starts a new
// profile and yields the ambient point, low advances the profile by one point.
// rsp channel: exactly one result per request: setpoint, phase, point number
// and a finished flag that is high on the last point and on every repeat of it.
// csr channel: register index and write data, always ready; the user must see
// that registers are written only while no request is in flight, since the
// block does not enforce it; an index outside the eight registers is ignored.
// timing: a tick updates the profile state on its transfer; the emit state
// then loads the output register once it is free. a restart first makes three
// passes (start, 17 quotient bits, store) through the shared restoring divider
// to work out the two ramp lengths and the cooldown step.
// a new request is taken as soon as the previous result is in the output
// register, even if the receiver has not taken it yet; when rsp_ready stays
// low the next result waits in the controller until the register is free.
// reset: registers return to their default profile, the setpoint to 25 with
// profile length 0, so ticks before the first restart repeat the ambient point
// with finished high.
module reflow_profile_setpoint_generator_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rpsg_pkg::IDX_W-1:0]    csr_index,
   input  logic [rpsg_pkg::DATA_W-1:0]   csr_wdata,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_restart,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rpsg_pkg::TEMP_W-1:0]   rsp_setpoint,
   output logic [2:0]                    rsp_phase,
   output logic [rpsg_pkg::PT_W-1:0]     rsp_point_number,
   output logic                          rsp_finished
);

   rpsg_pkg::ctrl_cmd_type  cmd;
   rpsg_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   rpsg_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_restart (req_restart),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .status      (status),
      .cmd         (cmd)
   );

   rpsg_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .status           (status),
      .rsp_setpoint     (rsp_setpoint),
      .rsp_phase        (rsp_phase),
      .rsp_point_number (rsp_point_number),
      .rsp_finished     (rsp_finished)
   );

endmodule

// ===== rtl/rpsg_div.sv =====
module rpsg_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rpsg_pkg::DIV_W-1:0]    dividend,
   input  logic [rpsg_pkg::SEC_W-1:0]    divisor,
   output logic                          done,
   output logic [rpsg_pkg::DIV_W-1:0]    quotient
);

   logic [rpsg_pkg::DIV_W-1:0]     quo_ff, quo_in;
   logic [rpsg_pkg::SEC_W-1:0]     rem_ff, rem_in;
   logic [rpsg_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic [rpsg_pkg::SEC_W:0]       trial;
   logic [rpsg_pkg::SEC_W:0]       diff;
   logic                           fits;

   // restoring division, one quotient bit per cycle
   always_comb begin
      trial  = {rem_ff, quo_ff[rpsg_pkg::DIV_W-1]};
      diff   = trial - {1'b0, divisor};
      fits   = (trial >= {1'b0, divisor});
      done   = busy_ff && (cnt_ff == '0);
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = rpsg_pkg::DIV_CNT_W'(rpsg_pkg::DIV_W);
         busy_in = 1'b1;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[rpsg_pkg::DIV_W-2:0], fits};
         rem_in = fits ? diff[rpsg_pkg::SEC_W-1:0] : trial[rpsg_pkg::SEC_W-1:0];
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign quotient = quo_ff;

endmodule

// ===== rtl/rpsg_dp.sv =====
module rpsg_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic [rpsg_pkg::IDX_W-1:0]    csr_index,
   input  logic [rpsg_pkg::DATA_W-1:0]   csr_wdata,
   input  rpsg_pkg::ctrl_cmd_type        cmd,
   output rpsg_pkg::dp_status_type       status,
   output logic [rpsg_pkg::TEMP_W-1:0]   rsp_setpoint,
   output logic [2:0]                    rsp_phase,
   output logic [rpsg_pkg::PT_W-1:0]     rsp_point_number,
   output logic                          rsp_finished
);

   localparam int F = rpsg_pkg::FRAC_BITS;
   localparam int TW = rpsg_pkg::TEMP_W;
   localparam int AW = rpsg_pkg::ACC_W;
   localparam int SW = rpsg_pkg::STEP_W;

   // configuration
   logic [TW-1:0]               soak_lvl_ff, peak_lvl_ff, cool_floor_ff;
   logic [rpsg_pkg::RISE_W-1:0] preheat_rise_ff, peak_rise_ff;
   logic [rpsg_pkg::SEC_W-1:0]  soak_sec_ff, reflow_sec_ff, cool_sec_ff;

   // profile state
   logic [TW-1:0]               temp_ff, temp_in;
   rpsg_pkg::phase_type         phase_ff, phase_in;
   logic [rpsg_pkg::SEC_W-1:0]  psec_ff, psec_in;
   logic [rpsg_pkg::PT_W-1:0]   pc_ff, pc_in;
   logic [rpsg_pkg::PT_W-1:0]   len_ff, len_in;
   logic signed [AW-1:0]        acc_ff, acc_in;
   logic signed [SW-1:0]        step_ff, step_in;
   logic [TW-1:0]               q1_ff, q1_in, q2_ff, q2_in;

   // output register
   logic [TW-1:0]               out_temp_ff;
   logic [2:0]                  out_phase_ff;
   logic [rpsg_pkg::PT_W-1:0]   out_pc_ff;
   logic                        out_fin_ff;

   // divider operands
   logic [rpsg_pkg::DIV_W-1:0]  div_num;
   logic [rpsg_pkg::SEC_W-1:0]  div_den;
   logic                        div_done;
   logic [rpsg_pkg::DIV_W-1:0]  div_quo;
   logic [rpsg_pkg::DIV_W-1:0]  quo_safe;
   logic                        step_neg;
   logic [TW-1:0]               cool_diff;

   // advance logic
   logic [rpsg_pkg::LEN_W-1:0]  pc_next;
   logic                        more;
   logic [TW:0]                 pre_sum, ramp_sum;
   logic [rpsg_pkg::SEC_W-1:0]  sec_soak, sec_reflow, sec_cool;
   rpsg_pkg::phase_type         np;
   logic [TW-1:0]               nt;
   logic                        cool_path;
   logic signed [AW-1:0]        acc_base, acc_new, acc_round, v, v_cl, floor_ext;
   logic [rpsg_pkg::LEN_W-1:0]  len_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         soak_lvl_ff     <= TW'(150);
         preheat_rise_ff <= rpsg_pkg::RISE_W'(2);
         soak_sec_ff     <= rpsg_pkg::SEC_W'(90);
         peak_lvl_ff     <= TW'(240);
         peak_rise_ff    <= rpsg_pkg::RISE_W'(2);
         reflow_sec_ff   <= rpsg_pkg::SEC_W'(30);
         cool_sec_ff     <= rpsg_pkg::SEC_W'(60);
         cool_floor_ff   <= TW'(50);
      end else if (csr_valid) begin
         unique case (csr_index)
            rpsg_pkg::CSR_SOAK_LEVEL:  soak_lvl_ff     <= csr_wdata[TW-1:0];
            rpsg_pkg::CSR_PREHEAT:     preheat_rise_ff <= csr_wdata[rpsg_pkg::RISE_W-1:0];
            rpsg_pkg::CSR_SOAK_SEC:    soak_sec_ff     <= csr_wdata;
            rpsg_pkg::CSR_PEAK_LEVEL:  peak_lvl_ff     <= csr_wdata[TW-1:0];
            rpsg_pkg::CSR_PEAK_RISE:   peak_rise_ff    <= csr_wdata[rpsg_pkg::RISE_W-1:0];
            rpsg_pkg::CSR_REFLOW_SEC:  reflow_sec_ff   <= csr_wdata;
            rpsg_pkg::CSR_COOL_SEC:    cool_sec_ff     <= csr_wdata;
            rpsg_pkg::CSR_COOL_FLOOR:  cool_floor_ff   <= csr_wdata[TW-1:0];
            default: ;
         endcase
      end
   end

   // divider operand select, held steady by the controller during a division
   always_comb begin
      step_neg  = (peak_lvl_ff < cool_floor_ff);
      cool_diff = step_neg ? (cool_floor_ff - peak_lvl_ff)
                           : (peak_lvl_ff - cool_floor_ff);
      div_num = '0;
      div_den = '0;
      case (cmd.div_sel)
         rpsg_pkg::SEL_PRE: begin
            if (soak_lvl_ff > rpsg_pkg::AMBIENT_TEMP)
               div_num = rpsg_pkg::DIV_W'(soak_lvl_ff - rpsg_pkg::AMBIENT_TEMP);
            div_den = rpsg_pkg::SEC_W'(preheat_rise_ff);
         end
         rpsg_pkg::SEL_RAMP: begin
            if (peak_lvl_ff > soak_lvl_ff)
               div_num = rpsg_pkg::DIV_W'(peak_lvl_ff - soak_lvl_ff);
            div_den = rpsg_pkg::SEC_W'(peak_rise_ff);
         end
         default: begin
            div_num = {cool_diff, {F{1'b0}}};
            div_den = cool_sec_ff;
         end
      endcase
      quo_safe = (div_den == '0) ? '0 : div_quo;
   end

   rpsg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign status.div_done = div_done;

   // one second of the profile, the restart and the stored divider results
   always_comb begin
      pc_next    = {1'b0, pc_ff} + 1'b1;
      more       = (pc_next < {1'b0, len_ff});
      pre_sum    = {1'b0, temp_ff} + (TW+1)'(preheat_rise_ff);
      ramp_sum   = {1'b0, temp_ff} + (TW+1)'(peak_rise_ff);
      sec_soak   = (phase_ff == rpsg_pkg::PH_SOAK)   ? psec_ff : '0;
      sec_reflow = (phase_ff == rpsg_pkg::PH_REFLOW) ? psec_ff : '0;
      sec_cool   = (phase_ff == rpsg_pkg::PH_COOL)   ? psec_ff : '0;

      acc_base  = (phase_ff != rpsg_pkg::PH_COOL)
                ? AW'({temp_ff, {F{1'b0}}}) : acc_ff;
      acc_new   = acc_base - AW'(step_ff);
      acc_round = acc_new + AW'(1 << (F - 1));
      v         = acc_round >>> F;
      floor_ext = AW'(cool_floor_ff);
      v_cl      = (v < floor_ext) ? floor_ext : v;

      cool_path = 1'b0;
      np        = rpsg_pkg::PH_HOLD;
      nt        = temp_ff;
      if (phase_ff <= rpsg_pkg::PH_PREHEAT && preheat_rise_ff != '0
          && pre_sum <= {1'b0, soak_lvl_ff}) begin
         np = rpsg_pkg::PH_PREHEAT;
         nt = pre_sum[TW-1:0];
      end else if (phase_ff <= rpsg_pkg::PH_SOAK && sec_soak < soak_sec_ff) begin
         np = rpsg_pkg::PH_SOAK;
         nt = soak_lvl_ff;
      end else if (phase_ff <= rpsg_pkg::PH_RAMP && peak_rise_ff != '0
                   && ramp_sum <= {1'b0, peak_lvl_ff}) begin
         np = rpsg_pkg::PH_RAMP;
         nt = ramp_sum[TW-1:0];
      end else if (phase_ff <= rpsg_pkg::PH_REFLOW && sec_reflow < reflow_sec_ff) begin
         np = rpsg_pkg::PH_REFLOW;
         nt = peak_lvl_ff;
      end else if (phase_ff <= rpsg_pkg::PH_COOL && sec_cool < cool_sec_ff) begin
         np        = rpsg_pkg::PH_COOL;
         nt        = v_cl[TW-1:0];
         cool_path = 1'b1;
      end

      len_sum = rpsg_pkg::LEN_W'(q1_ff) + rpsg_pkg::LEN_W'(soak_sec_ff)
              + rpsg_pkg::LEN_W'(q2_ff) + rpsg_pkg::LEN_W'(reflow_sec_ff)
              + rpsg_pkg::LEN_W'(cool_sec_ff) + 1'b1;

      temp_in  = temp_ff;
      phase_in = phase_ff;
      psec_in  = psec_ff;
      pc_in    = pc_ff;
      len_in   = len_ff;
      acc_in   = acc_ff;
      step_in  = step_ff;
      q1_in    = q1_ff;
      q2_in    = q2_ff;

      if (cmd.restart) begin
         temp_in  = rpsg_pkg::AMBIENT_TEMP;
         phase_in = rpsg_pkg::PH_AMBIENT;
         psec_in  = '0;
         pc_in    = '0;
         acc_in   = '0;
      end else if (cmd.tick && more) begin
         pc_in   = pc_next[rpsg_pkg::PT_W-1:0];
         temp_in = nt;
         if (cool_path)
            acc_in = acc_new;
         if (np == phase_ff) begin
            if (psec_ff != '1)
               psec_in = psec_ff + 1'b1;
         end else begin
            phase_in = np;
            psec_in  = rpsg_pkg::SEC_W'(1);
         end
      end

      if (cmd.div_store) begin
         case (cmd.div_sel)
            rpsg_pkg::SEL_PRE:  q1_in = quo_safe[TW-1:0];
            rpsg_pkg::SEL_RAMP: q2_in = quo_safe[TW-1:0];
            default: begin
               step_in = step_neg ? -SW'(quo_safe) : SW'(quo_safe);
               len_in  = len_sum[rpsg_pkg::PT_W] ? '1 : len_sum[rpsg_pkg::PT_W-1:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_ff  <= rpsg_pkg::AMBIENT_TEMP;
         phase_ff <= rpsg_pkg::PH_AMBIENT;
         psec_ff  <= '0;
         pc_ff    <= '0;
         len_ff   <= '0;
         acc_ff   <= '0;
         step_ff  <= '0;
      end else begin
         temp_ff  <= temp_in;
         phase_ff <= phase_in;
         psec_ff  <= psec_in;
         pc_ff    <= pc_in;
         len_ff   <= len_in;
         acc_ff   <= acc_in;
         step_ff  <= step_in;
      end
      q1_ff <= q1_in;
      q2_ff <= q2_in;
      if (cmd.load_out) begin
         out_temp_ff  <= temp_ff;
         out_phase_ff <= phase_ff;
         out_pc_ff    <= pc_ff;
         out_fin_ff   <= !more;
      end
   end

   assign rsp_setpoint     = out_temp_ff;
   assign rsp_phase        = out_phase_ff;
   assign rsp_point_number = out_pc_ff;
   assign rsp_finished     = out_fin_ff;

endmodule

// ===== rtl/rpsg_ctrl.sv =====
module rpsg_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_restart,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  rpsg_pkg::dp_status_type  status,
   output rpsg_pkg::ctrl_cmd_type   cmd
);

   rpsg_pkg::ctrl_state_type state_ff, state_in;
   rpsg_pkg::div_sel_type    sel_ff, sel_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rpsg_pkg::ST_IDLE;
         sel_ff       <= rpsg_pkg::SEL_PRE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      sel_in        = sel_ff;
      req_ready     = 1'b0;
      out_free      = !rsp_valid_ff || rsp_ready;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      cmd           = '0;
      cmd.div_sel   = sel_ff;
      unique case (state_ff)
         rpsg_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.restart = req_restart;
               cmd.tick    = !req_restart;
               sel_in      = rpsg_pkg::SEL_PRE;
               state_in    = req_restart ? rpsg_pkg::ST_DIV_START : rpsg_pkg::ST_EMIT;
            end
         end
         rpsg_pkg::ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = rpsg_pkg::ST_DIV_WAIT;
         end
         rpsg_pkg::ST_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.div_store = 1'b1;
               unique case (sel_ff)
                  rpsg_pkg::SEL_PRE: begin
                     sel_in   = rpsg_pkg::SEL_RAMP;
                     state_in = rpsg_pkg::ST_DIV_START;
                  end
                  rpsg_pkg::SEL_RAMP: begin
                     sel_in   = rpsg_pkg::SEL_STEP;
                     state_in = rpsg_pkg::ST_DIV_START;
                  end
                  default: state_in = rpsg_pkg::ST_EMIT;
               endcase
            end
         end
         rpsg_pkg::ST_EMIT: begin
            // wait for the output register to drain before the next transfer
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = rpsg_pkg::ST_IDLE;
            end
         end
         default: state_in = rpsg_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== test/tb_reflow_profile_setpoint_generator_core.sv =====
`timescale 1ns / 100ps

module tb_reflow_profile_setpoint_generator_core;

   localparam int CSR_COUNT = 8;
   localparam int MAX_POINT = (1 << rpsg_pkg::PT_W) - 1;

   typedef struct packed {
      logic [rpsg_pkg::TEMP_W-1:0] setpoint;
      rpsg_pkg::phase_type         phase;
      logic [rpsg_pkg::PT_W-1:0]   point;
      logic                        finished;
   } setpoint_point_type;

   class setpoint_scoreboard_type;
      logic [rpsg_pkg::TEMP_W-1:0] soak_lvl, peak_lvl, cool_floor;
      logic [rpsg_pkg::RISE_W-1:0] preheat_rise, peak_rise;
      logic [rpsg_pkg::SEC_W-1:0]  soak_sec, reflow_sec, cool_sec;

      logic [rpsg_pkg::TEMP_W-1:0] cur_temp;
      rpsg_pkg::phase_type         cur_phase;
      logic [rpsg_pkg::SEC_W-1:0]  phase_sec;
      logic [rpsg_pkg::PT_W-1:0]   point_cnt, profile_len;
      int                          cool_acc, cool_step;

      setpoint_point_type expected_points[$];
      int errors, checked, finished_seen, cool_seen, hold_seen;

      function new();
         soak_lvl = 150; preheat_rise = 2; soak_sec = 90;
         peak_lvl = 240; peak_rise = 2; reflow_sec = 30;
         cool_sec = 60; cool_floor = 50;
         cur_temp = rpsg_pkg::AMBIENT_TEMP; cur_phase = rpsg_pkg::PH_AMBIENT;
         phase_sec = 0;
         point_cnt = 0; profile_len = 0; cool_acc = 0; cool_step = 0;
         errors = 0; checked = 0; finished_seen = 0; cool_seen = 0; hold_seen = 0;
      endfunction

      function void write_reg(logic [rpsg_pkg::IDX_W-1:0] idx,
                              logic [rpsg_pkg::DATA_W-1:0] d);
         case (idx)
            rpsg_pkg::CSR_SOAK_LEVEL: soak_lvl = d[rpsg_pkg::TEMP_W-1:0];
            rpsg_pkg::CSR_PREHEAT:    preheat_rise = d[rpsg_pkg::RISE_W-1:0];
            rpsg_pkg::CSR_SOAK_SEC:   soak_sec = d[rpsg_pkg::SEC_W-1:0];
            rpsg_pkg::CSR_PEAK_LEVEL: peak_lvl = d[rpsg_pkg::TEMP_W-1:0];
            rpsg_pkg::CSR_PEAK_RISE:  peak_rise = d[rpsg_pkg::RISE_W-1:0];
            rpsg_pkg::CSR_REFLOW_SEC: reflow_sec = d[rpsg_pkg::SEC_W-1:0];
            rpsg_pkg::CSR_COOL_SEC:   cool_sec = d[rpsg_pkg::SEC_W-1:0];
            rpsg_pkg::CSR_COOL_FLOOR: cool_floor = d[rpsg_pkg::TEMP_W-1:0];
            default: ;
         endcase
      endfunction

      // seconds of a ramp as counted in the profile length
      function int ramp_len(int hi, int lo, int rise);
         if (rise == 0 || hi <= lo) return 0;
         return (hi - lo) / rise;
      endfunction

      function void move_to(rpsg_pkg::phase_type p, int temp);
         if (p == cur_phase) begin
            if (phase_sec < 1023) phase_sec++;
         end else begin
            cur_phase = p;
            phase_sec = 1;
         end
         cur_temp = rpsg_pkg::TEMP_W'(temp);
      endfunction

      function void next_second();
         int t, held, v;
         t = cur_temp;
         if (cur_phase <= rpsg_pkg::PH_PREHEAT && preheat_rise != 0
             && t + preheat_rise <= soak_lvl) begin
            move_to(rpsg_pkg::PH_PREHEAT, t + preheat_rise);
            return;
         end
         held = (cur_phase == rpsg_pkg::PH_SOAK) ? int'(phase_sec) : 0;
         if (cur_phase <= rpsg_pkg::PH_SOAK && held < soak_sec) begin
            move_to(rpsg_pkg::PH_SOAK, soak_lvl);
            return;
         end
         if (cur_phase <= rpsg_pkg::PH_RAMP && peak_rise != 0
             && t + peak_rise <= peak_lvl) begin
            move_to(rpsg_pkg::PH_RAMP, t + peak_rise);
            return;
         end
         held = (cur_phase == rpsg_pkg::PH_REFLOW) ? int'(phase_sec) : 0;
         if (cur_phase <= rpsg_pkg::PH_REFLOW && held < reflow_sec) begin
            move_to(rpsg_pkg::PH_REFLOW, peak_lvl);
            return;
         end
         held = (cur_phase == rpsg_pkg::PH_COOL) ? int'(phase_sec) : 0;
         if (cur_phase <= rpsg_pkg::PH_COOL && held < cool_sec) begin
            if (cur_phase != rpsg_pkg::PH_COOL) cool_acc = t * (1 << rpsg_pkg::FRAC_BITS);
            cool_acc -= cool_step;
            // round half up, floor on negative values
            v = (cool_acc + (1 << (rpsg_pkg::FRAC_BITS - 1))) >>> rpsg_pkg::FRAC_BITS;
            if (v < int'(cool_floor)) v = int'(cool_floor);
            move_to(rpsg_pkg::PH_COOL, v);
            return;
         end
         move_to(rpsg_pkg::PH_HOLD, t);
      endfunction

      function void note_request(bit restart);
         int len, diff;
         setpoint_point_type e;
         if (restart) begin
            len = ramp_len(soak_lvl, rpsg_pkg::AMBIENT_TEMP, preheat_rise) + soak_sec
                + ramp_len(peak_lvl, soak_lvl, peak_rise) + reflow_sec + cool_sec + 1;
            profile_len = (len > MAX_POINT) ? rpsg_pkg::PT_W'(MAX_POINT)
                                            : rpsg_pkg::PT_W'(len);
            diff = int'(peak_lvl) - int'(cool_floor);
            cool_step = (cool_sec == 0) ? 0
                      : (diff * (1 << rpsg_pkg::FRAC_BITS)) / int'(cool_sec);
            cur_temp = rpsg_pkg::AMBIENT_TEMP;
            cur_phase = rpsg_pkg::PH_AMBIENT;
            phase_sec = 0;
            point_cnt = 0;
            cool_acc = 0;
         end else if (int'(point_cnt) + 1 < int'(profile_len)) begin
            point_cnt++;
            next_second();
         end
         e.setpoint = cur_temp;
         e.phase = cur_phase;
         e.point = point_cnt;
         e.finished = (int'(point_cnt) + 1 >= int'(profile_len));
         expected_points.push_back(e);
      endfunction

      function void check_result(logic [rpsg_pkg::TEMP_W-1:0] sp, logic [2:0] ph,
                                 logic [rpsg_pkg::PT_W-1:0] pt, logic fin);
         setpoint_point_type e;
         if (expected_points.size() == 0) begin
            $error("setpoint result with no request outstanding");
            errors++;
            return;
         end
         e = expected_points.pop_front();
         checked++;
         if (sp !== e.setpoint) begin
            $error("setpoint: expected %0d, actual %0d", e.setpoint, sp);
            errors++;
         end
         if (ph !== e.phase) begin
            $error("phase: expected %0d, actual %0d", e.phase, ph);
            errors++;
         end
         if (pt !== e.point) begin
            $error("point_number: expected %0d, actual %0d", e.point, pt);
            errors++;
         end
         if (fin !== e.finished) begin
            $error("finished: expected %0d, actual %0d", e.finished, fin);
            errors++;
         end
         if (e.finished) finished_seen++;
         if (e.phase == rpsg_pkg::PH_COOL) cool_seen++;
         if (e.phase == rpsg_pkg::PH_HOLD) hold_seen++;
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [rpsg_pkg::IDX_W-1:0]    csr_index = '0;
   logic [rpsg_pkg::DATA_W-1:0]   csr_wdata = '0;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic                          req_restart = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [rpsg_pkg::TEMP_W-1:0]   rsp_setpoint;
   logic [2:0]                    rsp_phase;
   logic [rpsg_pkg::PT_W-1:0]     rsp_point_number;
   logic                          rsp_finished;

   int sender_idle = 0;
   int receiver_stall = 0;
   int restarts_sent = 0;
   int settings_run = 0;
   int idle_by_mode[4] = '{0, 78, 0, 11};
   int stall_by_mode[4] = '{0, 0, 78, 11};

   setpoint_scoreboard_type sb = new();

   always #5 clock = ~clock;

   reflow_profile_setpoint_generator_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_setpoint     (rsp_setpoint),
      .rsp_phase        (rsp_phase),
      .rsp_point_number (rsp_point_number),
      .rsp_finished     (rsp_finished)
   );

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1)
         sb.check_result(rsp_setpoint, rsp_phase, rsp_point_number, rsp_finished);
   end

   // one tick or restart transfer; valid stays high on return
   task automatic send_tick(bit restart);
      while ($urandom_range(99) < sender_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note_request(restart);
      if (restart) restarts_sent++;
      @(negedge clock);
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      while (sb.expected_points.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(logic [rpsg_pkg::IDX_W-1:0] idx,
                            logic [rpsg_pkg::DATA_W-1:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.write_reg(idx, d);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic load_profile(logic [rpsg_pkg::DATA_W-1:0] soak,
                               logic [rpsg_pkg::DATA_W-1:0] pre,
                               logic [rpsg_pkg::DATA_W-1:0] ssec,
                               logic [rpsg_pkg::DATA_W-1:0] reflow,
                               logic [rpsg_pkg::DATA_W-1:0] peak,
                               logic [rpsg_pkg::DATA_W-1:0] rsec,
                               logic [rpsg_pkg::DATA_W-1:0] csec,
                               logic [rpsg_pkg::DATA_W-1:0] floor_t);
      write_csr(rpsg_pkg::CSR_SOAK_LEVEL, soak);
      write_csr(rpsg_pkg::CSR_PREHEAT, pre);
      write_csr(rpsg_pkg::CSR_SOAK_SEC, ssec);
      write_csr(rpsg_pkg::CSR_PEAK_LEVEL, reflow);
      write_csr(rpsg_pkg::CSR_PEAK_RISE, peak);
      write_csr(rpsg_pkg::CSR_REFLOW_SEC, rsec);
      write_csr(rpsg_pkg::CSR_COOL_SEC, csec);
      write_csr(rpsg_pkg::CSR_COOL_FLOOR, floor_t);
      settings_run++;
   endtask

   task automatic random_profile();
      int soak, pre, ssec, reflow, peak, rsec, csec, floor_t;
      if ($urandom_range(4) == 0) begin
         // raw register values, upper data bits included
         soak = $urandom_range(1023); pre = $urandom_range(1023);
         ssec = $urandom_range(1023); reflow = $urandom_range(1023);
         peak = $urandom_range(1023); rsec = $urandom_range(1023);
         csec = $urandom_range(1023); floor_t = $urandom_range(1023);
      end else begin
         // short profiles so that cooldown and the end are reached often
         soak = ($urandom_range(9) == 0) ? $urandom_range(0, 40) : 25 + $urandom_range(60);
         pre = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 20);
         ssec = $urandom_range(8);
         reflow = ($urandom_range(9) == 0) ? $urandom_range(511) : soak + $urandom_range(60);
         if (reflow > 511) reflow = 511;
         peak = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 20);
         rsec = $urandom_range(6);
         csec = ($urandom_range(6) == 0) ? 0 : $urandom_range(1, 12);
         floor_t = ($urandom_range(4) == 0) ? $urandom_range(511) : $urandom_range(reflow);
      end
      load_profile(rpsg_pkg::DATA_W'(soak), rpsg_pkg::DATA_W'(pre),
                   rpsg_pkg::DATA_W'(ssec), rpsg_pkg::DATA_W'(reflow),
                   rpsg_pkg::DATA_W'(peak), rpsg_pkg::DATA_W'(rsec),
                   rpsg_pkg::DATA_W'(csec), rpsg_pkg::DATA_W'(floor_t));
      if ($urandom_range(2) == 0)
         write_csr(rpsg_pkg::IDX_W'($urandom_range(CSR_COUNT, (1 << rpsg_pkg::IDX_W) - 1)),
                   rpsg_pkg::DATA_W'($urandom));
   endtask

   initial begin : stimulus
      int budget, n;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // ticks before any restart repeat the ambient point, then the default profile
      send_tick(1'b0);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      pause_until_drained();

      // soak below ambient (bit 9 masked off), reflow below soak, floor above peak
      load_profile(10'h20a, 10'd1, 10'd2, 10'd5, 10'd1, 10'd1, 10'd4, 10'd100);
      write_csr(rpsg_pkg::IDX_W'(CSR_COUNT + 3), 10'h3ff);
      send_tick(1'b1);
      repeat (9) send_tick(1'b0);
      pause_until_drained();

      // no soak hold: the ramp runs past its counted length, no cooldown
      load_profile(10'd32, 10'd4, 10'd0, 10'd38, 10'd3, 10'd0, 10'd0, 10'd0);
      send_tick(1'b1);
      repeat (5) send_tick(1'b0);
      pause_until_drained();

      // both rises zero, written with a bit above the field width
      load_profile(10'd60, 10'h040, 10'd1, 10'd90, 10'h040, 10'd1, 10'd2, 10'd0);
      send_tick(1'b1);
      repeat (4) send_tick(1'b0);

      for (int s = 0; s < 16; s++) begin
         pause_until_drained();
         sender_idle = idle_by_mode[s % 4];
         receiver_stall = stall_by_mode[s % 4];
         if (s == 3)
            load_profile('1, '1, '1, '1, '1, '1, '1, '1);
         else if (s == 9)
            load_profile('0, '0, '0, '0, '0, '0, '0, '0);
         else
            random_profile();
         budget = 70;
         // registers changed under a running profile
         if ($urandom_range(3) == 0) begin
            n = $urandom_range(1, 3);
            repeat (n) send_tick(1'b0);
            budget -= n;
         end
         while (budget > 0) begin
            send_tick(1'b1);
            budget--;
            n = $urandom_range(0, int'(sb.profile_len) + 3);
            if ($urandom_range(9) == 0) n = $urandom_range(3);
            while (n > 0 && budget > 0) begin
               send_tick(1'b0);
               n--;
               budget--;
            end
         end
      end

      pause_until_drained();
      repeat (64) @(negedge clock);
      if (sb.expected_points.size() != 0) begin
         $error("%0d setpoint results never arrived", sb.expected_points.size());
         sb.errors++;
      end
      $display("checked %0d setpoints from %0d restarts across %0d register settings",
               sb.checked, restarts_sent, settings_run);
      $display("%0d cooldown points, %0d final-hold points, %0d points flagged finished",
               sb.cool_seen, sb.hold_seen, sb.finished_seen);
      if (sb.errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
